FILE: design/atac_pkg.sv
// Shared types, constants and the mnemonic table for the token and argument checker.
`timescale 1ns / 1ps

package atac_pkg;

  localparam int MnemCount   = 30;
  localparam int FirstOneArg = 2;
  localparam int FirstTwoArg = 19;
  localparam int FirstThrArg = 29;
  localparam int QueueDepth  = 4;

  localparam logic [2:0] LONG_TOKEN = 3'd5;
  localparam logic [2:0] MAX_CHARS  = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TOKEN   = 2'd1,
    MODE_COMMENT = 2'd2,
    MODE_HALT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    TERM_NONE  = 2'd0,
    TERM_COLON = 2'd1,
    TERM_SEMI  = 2'd2,
    TERM_COMMA = 2'd3
  } term_t;

  typedef enum logic [2:0] {
    KIND_LABEL   = 3'd0,
    KIND_COMMENT = 3'd1,
    KIND_COMMA   = 3'd2,
    KIND_INSTR   = 3'd3,
    KIND_ARG     = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] mnemonic;
    logic [1:0] arg_count;
    logic [1:0] args_left;
    logic       too_many;
    logic       run_end;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } match_t;

  localparam logic [7:0] MNEM_TXT [MnemCount][4] = '{
    '{"c", "l", "r", 8'h00}, '{"r", "e", "t", 8'h00}, '{"j", "m", "p", 8'h00},
    '{"c", "a", "l", "l"},   '{"s", "h", "r", 8'h00}, '{"s", "h", "l", 8'h00},
    '{"i", "n", "d", 8'h00}, '{"j", "m", "p", "0"},   '{"k", "s", "e", 8'h00},
    '{"k", "s", "n", 8'h00}, '{"d", "e", "l", 8'h00}, '{"w", "k", "p", 8'h00},
    '{"s", "e", "t", "d"},   '{"s", "e", "t", "s"},   '{"a", "d", "i", 8'h00},
    '{"s", "p", "r", 8'h00}, '{"s", "b", "i", 8'h00}, '{"s", "t", "o", 8'h00},
    '{"f", "i", "l", 8'h00}, '{"s", "e", 8'h00, 8'h00}, '{"s", "n", "e", 8'h00},
    '{"s", "e", "t", 8'h00}, '{"a", "d", "d", 8'h00}, '{"o", "r", 8'h00, 8'h00},
    '{"a", "n", "d", 8'h00}, '{"x", "o", "r", 8'h00}, '{"s", "u", "b", 8'h00},
    '{"s", "u", "b", "x"},   '{"r", "n", "d", 8'h00}, '{"d", "r", "a", "w"}
  };

  localparam logic [2:0] MNEM_LEN [MnemCount] = '{
    3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  // Compare the token against all mnemonics in parallel; first hit wins.
  function automatic match_t find_mnem(input logic [7:0] chars [4], input logic [2:0] len);
    match_t m;
    logic   eq;
    m = '0;
    for (int i = 0; i < MnemCount; i++) begin
      eq = (len == MNEM_LEN[i]);
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < len && chars[j] != MNEM_TXT[i][j]) eq = 1'b0;
      end
      if (eq && !m.hit) begin
        m.hit = 1'b1;
        m.idx = 5'(i);
      end
    end
    return m;
  endfunction

  function automatic logic [1:0] mnem_args(input logic [4:0] idx);
    logic [1:0] n;
    if (idx < 5'(FirstOneArg)) n = 2'd0;
    else if (idx < 5'(FirstTwoArg)) n = 2'd1;
    else if (idx < 5'(FirstThrArg)) n = 2'd2;
    else n = 2'd3;
    return n;
  endfunction

endpackage

FILE: design/atac_scan.sv
// Character scanner: token state, classification and argument counting.
`timescale 1ns / 1ps

module atac_scan import atac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       fin,
  output push_t      push
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] chars_r [4];
  logic [7:0] chars_nxt [4];
  logic [2:0] len_r, len_nxt;
  logic [1:0] left_r, left_nxt;

  logic       sep_ev, open_tok, start, app, do_fin, cd, over, end_res;
  term_t      term;
  logic [2:0] tok_len;
  logic [1:0] left_f;
  mode_t      mode_f;
  match_t     mt;
  res_t       fres, eres;

  // Decode the byte against the current mode.
  always_comb begin
    term   = TERM_NONE;
    sep_ev = 1'b0;
    start  = 1'b0;
    app    = 1'b0;
    case (ch)
      CH_COLON: term = TERM_COLON;
      CH_SEMI:  term = TERM_SEMI;
      CH_COMMA: term = TERM_COMMA;
      default:  term = TERM_NONE;
    endcase
    case (mode_r)
      MODE_IDLE: begin
        if (!is_space(ch)) begin
          if (term != TERM_NONE) sep_ev = 1'b1;
          else start = 1'b1;
        end
      end
      MODE_TOKEN: begin
        if (is_space(ch) || term != TERM_NONE) sep_ev = 1'b1;
        else app = 1'b1;
      end
      default: ;
    endcase
    open_tok = start || app;
    do_fin   = sep_ev || (fin && open_tok);
  end

  // Token buffer after this byte.
  always_comb begin
    chars_nxt = chars_r;
    tok_len   = len_r;
    if (start) begin
      chars_nxt[0] = ch;
      tok_len      = 3'd1;
    end else if (app) begin
      if (len_r < MAX_CHARS) chars_nxt[len_r[1:0]] = ch;
      if (len_r < LONG_TOKEN) tok_len = len_r + 3'd1;
    end
    mt = find_mnem(chars_nxt, tok_len);
  end

  // Next state.
  always_comb begin
    cd = (term == TERM_COMMA && mode_r == MODE_TOKEN) ||
         (term == TERM_NONE && !mt.hit);
    cd   = cd && do_fin;
    over = cd && (left_r == 2'd0);
    if (do_fin && term == TERM_NONE && mt.hit) left_f = mnem_args(mt.idx);
    else if (cd && !over) left_f = left_r - 2'd1;
    else left_f = left_r;

    if (do_fin) begin
      if (over) mode_f = MODE_HALT;
      else if (term == TERM_SEMI) mode_f = MODE_COMMENT;
      else mode_f = MODE_IDLE;
    end else if (open_tok) begin
      mode_f = MODE_TOKEN;
    end else if (mode_r == MODE_COMMENT && ch == CH_LF) begin
      mode_f = MODE_IDLE;
    end else begin
      mode_f = mode_r;
    end
    end_res = fin && (mode_f != MODE_HALT);

    if (fin) begin
      mode_nxt = MODE_IDLE;
      len_nxt  = 3'd0;
      left_nxt = 2'd0;
    end else begin
      mode_nxt = mode_f;
      len_nxt  = do_fin ? 3'd0 : tok_len;
      left_nxt = left_f;
    end
  end

  // Results of this byte.
  always_comb begin
    fres = '0;
    case (term)
      TERM_COLON: fres.kind = KIND_LABEL;
      TERM_SEMI:  fres.kind = KIND_COMMENT;
      TERM_COMMA: fres.kind = KIND_COMMA;
      default:    fres.kind = mt.hit ? KIND_INSTR : KIND_ARG;
    endcase
    if (term == TERM_NONE && mt.hit) begin
      fres.mnemonic  = mt.idx;
      fres.arg_count = left_f;
    end
    fres.args_left = left_f;
    fres.too_many  = over;
    fres.run_end   = !end_res;

    eres           = '0;
    eres.kind      = KIND_END;
    eres.args_left = left_f;
    eres.run_end   = 1'b1;

    push.r0  = do_fin ? fres : eres;
    push.r1  = eres;
    push.cnt = step ? (2'(do_fin) + 2'(end_res)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= 3'd0;
      left_r <= 2'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) chars_r <= chars_nxt;
  end

  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HALT |-> left_r == 2'd0)
    else $error("halted text with arguments left");

  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && fin |=> mode_r == MODE_IDLE && len_r == 3'd0 && left_r == 2'd0)
    else $error("state not cleared after end of text");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_r == MODE_HALT |-> push.cnt == 2'd0)
    else $error("result produced while halted");

endmodule

FILE: design/atac_rq.sv
// Result queue: takes up to two results a cycle, hands out one beat a cycle while the output is ready.
`timescale 1ns / 1ps

module atac_rq import atac_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output res_t  head,
  output logic  head_valid,
  output logic  room
);

  res_t       mem_r [QueueDepth];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  always_comb begin
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + 2'(do_pop);
    count_nxt  = count_r + 3'(push.cnt) - 3'(do_pop);
  end

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != 3'd0);
  // Space for a two-result byte regardless of the output side.
  assign room       = (count_r <= 3'(QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + 2'd1] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QueueDepth))
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: design/assembler_token_arg_checker_top.sv
// An accepted input beat is registered, scanned, then written to the result queue before output.
// Throughput: one character per cycle while the queue has room; each result is one out beat.
// The rate is set by the single scan stage between the input register and the result queue.
// A four-entry result queue decouples the output; input stalls only when it holds over two.
// Reset (rst_n low, synchronous): scanner between tokens, counts cleared, queue emptied.
`timescale 1ns / 1ps

module assembler_token_arg_checker_top import atac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // final_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] mnemonic, [6:5] arg_count, [8:7] args_left, zero fill
  output logic [3:0]  out_tuser,  // [2:0] kind, [3] too_many
  output logic        out_tlast   // run_end
);

  logic       in_valid_r;
  logic [7:0] in_ch_r;
  logic       in_fin_r;
  logic       fire, room;
  push_t      push;
  res_t       head;

  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Hold the beat until the scanner takes it.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r  <= in_tdata;
      in_fin_r <= in_tlast;
    end
  end

  atac_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .ch    (in_ch_r),
    .fin   (in_fin_r),
    .push  (push)
  );

  atac_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room)
  );

  assign out_tdata = {7'd0, head.args_left, head.arg_count, head.mnemonic};
  assign out_tuser = {head.too_many, head.kind};
  assign out_tlast = head.run_end;

endmodule
